// File: rtl/lmfb_pkg.sv
package lmfb_pkg;

   localparam int BUFFER_ROWS_DEFAULT  = 16;
   localparam int VISIBLE_ROWS_DEFAULT = 8;

   localparam int ROW_W     = 8;
   localparam int LINE_W    = 4;
   localparam int COLUMN_W  = 3;
   localparam int ADDR_W    = 4;
   localparam int STEP_W    = 3;
   localparam int INTENS_W  = 4;
   localparam int SCAN_W    = 3;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 4;
   localparam int INIT_WORDS = 5;

   localparam logic [CSR_IDX_W-1:0] CSR_INTENSITY  = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCAN_LIMIT = 1'd1;

   localparam logic [INTENS_W-1:0] INTENSITY_RESET  = 4'd3;
   localparam logic [SCAN_W-1:0]   SCAN_LIMIT_RESET = 3'd7;

   localparam logic [ADDR_W-1:0] ADDR_DECODE       = 4'h9;
   localparam logic [ADDR_W-1:0] ADDR_INTENSITY    = 4'ha;
   localparam logic [ADDR_W-1:0] ADDR_SCAN_LIMIT   = 4'hb;
   localparam logic [ADDR_W-1:0] ADDR_SHUTDOWN     = 4'hc;
   localparam logic [ADDR_W-1:0] ADDR_DISPLAY_TEST = 4'hf;

   localparam logic [ROW_W-1:0] DATA_NO_DECODE = 8'h00;
   localparam logic [ROW_W-1:0] DATA_RUN       = 8'h01;
   localparam logic [ROW_W-1:0] DATA_TEST_OFF  = 8'h00;

   typedef enum logic [2:0] {
      CMD_INIT      = 3'd0,
      CMD_SET_PIXEL = 3'd1,
      CMD_CLR_PIXEL = 3'd2,
      CMD_WRITE_ROW = 3'd3,
      CMD_SHIFT     = 3'd4,
      CMD_REFRESH   = 3'd5,
      CMD_CLEAR_ALL = 3'd6
   } cmd_type;

   typedef enum logic [2:0] {
      FOP_NONE,
      FOP_SET,
      FOP_CLEAR,
      FOP_WRITE,
      FOP_SHIFT,
      FOP_ZERO
   } frame_op_type;

   typedef enum logic {
      SRC_INIT,
      SRC_ROW
   } word_src_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_INIT_RUN,
      ST_REFRESH_RUN
   } state_type;

   typedef struct packed {
      frame_op_type frame_op;
      logic         step_clear;
      logic         emit;
      word_src_type src;
   } ctrl_type;

   typedef struct packed {
      logic slot_free;
      logic init_last;
      logic row_last;
   } status_type;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [ROW_W-1:0]  data;
   } word_type;

   function automatic word_type init_word(input logic [STEP_W-1:0] step,
                                          input logic [INTENS_W-1:0] intensity,
                                          input logic [SCAN_W-1:0] scan_limit);
      word_type w;
      case (step)
         3'd0: w = '{addr: ADDR_DECODE, data: DATA_NO_DECODE};
         3'd1: w = '{addr: ADDR_INTENSITY, data: {4'd0, intensity}};
         3'd2: w = '{addr: ADDR_SCAN_LIMIT, data: {5'd0, scan_limit}};
         3'd3: w = '{addr: ADDR_SHUTDOWN, data: DATA_RUN};
         default: w = '{addr: ADDR_DISPLAY_TEST, data: DATA_TEST_OFF};
      endcase
      return w;
   endfunction

endpackage

// File: rtl/lmfb_ctrl.sv
module lmfb_ctrl import lmfb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [2:0]          req_command,
   input  status_type          status,
   output ctrl_type            ctrl
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      req_ready       = 1'b0;
      ctrl.frame_op   = FOP_NONE;
      ctrl.step_clear = 1'b0;
      ctrl.emit       = 1'b0;
      ctrl.src        = SRC_INIT;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (cmd_type'(req_command))
                  CMD_INIT: begin
                     ctrl.step_clear = 1'b1;
                     state_in        = ST_INIT_RUN;
                  end
                  CMD_SET_PIXEL: ctrl.frame_op = FOP_SET;
                  CMD_CLR_PIXEL: ctrl.frame_op = FOP_CLEAR;
                  CMD_WRITE_ROW: ctrl.frame_op = FOP_WRITE;
                  CMD_SHIFT:     ctrl.frame_op = FOP_SHIFT;
                  CMD_REFRESH: begin
                     ctrl.step_clear = 1'b1;
                     state_in        = ST_REFRESH_RUN;
                  end
                  CMD_CLEAR_ALL: begin
                     ctrl.frame_op   = FOP_ZERO;
                     ctrl.step_clear = 1'b1;
                     state_in        = ST_REFRESH_RUN;
                  end
                  default: ;
               endcase
            end
         end
         ST_INIT_RUN: begin
            ctrl.src = SRC_INIT;
            if (status.slot_free) begin
               ctrl.emit = 1'b1;
               if (status.init_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_REFRESH_RUN: begin
            ctrl.src = SRC_ROW;
            if (status.slot_free) begin
               ctrl.emit = 1'b1;
               if (status.row_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_no_emit_in_idle: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !ctrl.emit)
      else $error("word emitted while idle");

   a_init_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_INIT_RUN && status.slot_free && status.init_last |=> state_ff == ST_IDLE)
      else $error("init run did not end after last word");

   a_refresh_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_REFRESH_RUN && status.slot_free && status.row_last
      |=> state_ff == ST_IDLE)
      else $error("refresh run did not end after last word");

endmodule

// File: rtl/lmfb_datapath.sv
module lmfb_datapath import lmfb_pkg::*; #(
   parameter int BUFFER_ROWS  = BUFFER_ROWS_DEFAULT,
   parameter int VISIBLE_ROWS = VISIBLE_ROWS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [COLUMN_W-1:0]  req_column,
   input  logic [LINE_W-1:0]    req_line,
   input  logic [ROW_W-1:0]     req_row_bits,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_write_data,
   input  ctrl_type             ctrl,
   output status_type           status,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ADDR_W-1:0]    rsp_reg_address,
   output logic [ROW_W-1:0]     rsp_reg_data,
   output logic                 rsp_last
);

   localparam int IDX_W = $clog2(BUFFER_ROWS);

   logic [ROW_W-1:0]    rows_ff [BUFFER_ROWS];
   logic [INTENS_W-1:0] intensity_ff;
   logic [SCAN_W-1:0]   scan_limit_ff;
   logic [STEP_W-1:0]   step_ff;
   logic                rsp_valid_ff;
   logic [ADDR_W-1:0]   rsp_addr_ff;
   logic [ROW_W-1:0]    rsp_data_ff;
   logic                rsp_last_ff;

   logic [IDX_W-1:0] read_idx;
   logic [IDX_W-1:0] write_idx;
   logic [ROW_W-1:0] read_row;
   logic [ROW_W-1:0] mask;
   logic             line_in_range;
   word_type         init_w;
   word_type         word_in;
   logic             word_last;

   assign mask          = ROW_W'(1) << (3'd7 - req_column);
   assign line_in_range = int'(req_line) < BUFFER_ROWS;
   assign write_idx     = IDX_W'(req_line);
   assign read_idx      = (ctrl.frame_op == FOP_SET || ctrl.frame_op == FOP_CLEAR)
                          ? IDX_W'(req_line[2:0]) : IDX_W'(step_ff);
   assign read_row      = rows_ff[read_idx];

   assign status.init_last = step_ff == STEP_W'(INIT_WORDS - 1);
   assign status.row_last  = step_ff == STEP_W'(VISIBLE_ROWS - 1);
   assign status.slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      init_w = init_word(step_ff, intensity_ff, scan_limit_ff);
      if (ctrl.src == SRC_INIT) begin
         word_in   = init_w;
         word_last = status.init_last;
      end else begin
         word_in.addr = ADDR_W'(step_ff) + ADDR_W'(1);
         word_in.data = read_row;
         word_last    = status.row_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < BUFFER_ROWS; i++) begin
            rows_ff[i] <= '0;
         end
      end else begin
         case (ctrl.frame_op)
            FOP_SET:   rows_ff[read_idx] <= read_row | mask;
            FOP_CLEAR: rows_ff[read_idx] <= read_row & ~mask;
            FOP_WRITE: begin
               if (line_in_range) begin
                  rows_ff[write_idx] <= req_row_bits;
               end
            end
            FOP_SHIFT: begin
               for (int i = 0; i < BUFFER_ROWS - 1; i++) begin
                  rows_ff[i] <= rows_ff[i+1];
               end
               rows_ff[BUFFER_ROWS-1] <= '0;
            end
            FOP_ZERO: begin
               for (int i = 0; i < BUFFER_ROWS; i++) begin
                  rows_ff[i] <= '0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         intensity_ff  <= INTENSITY_RESET;
         scan_limit_ff <= SCAN_LIMIT_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_INTENSITY:  intensity_ff  <= csr_write_data;
            CSR_SCAN_LIMIT: scan_limit_ff <= csr_write_data[SCAN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (ctrl.step_clear) begin
            step_ff <= '0;
         end else if (ctrl.emit) begin
            step_ff <= step_ff + STEP_W'(1);
         end
         if (ctrl.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.emit) begin
         rsp_addr_ff <= word_in.addr;
         rsp_data_ff <= word_in.data;
         rsp_last_ff <= word_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_reg_address = rsp_addr_ff;
   assign rsp_reg_data    = rsp_data_ff;
   assign rsp_last        = rsp_last_ff;

   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      ctrl.emit |-> (!rsp_valid_ff || rsp_ready))
      else $error("beat overwritten before taken");

   a_zero_clears_row0: assert property (@(posedge clock) disable iff (reset)
      ctrl.frame_op == FOP_ZERO |=> rows_ff[0] == '0)
      else $error("clear all left data in buffer");

   a_shift_tail_zero: assert property (@(posedge clock) disable iff (reset)
      ctrl.frame_op == FOP_SHIFT |=> rows_ff[BUFFER_ROWS-1] == '0)
      else $error("shift did not zero last row");

endmodule

// File: rtl/led_matrix_frame_buffer_top.sv
// frame commands (set, clear, write row, shift) update the frame buffer as they are accepted
// init: 5 beats via state and output registers, 1 beat per cycle while rsp_ready holds
// refresh and clear all: VISIBLE_ROWS beats at 1 per cycle while rsp_ready holds
// rate is set by the output register, one driver word per cycle unless the sink stalls
// synchronous active-high reset zeroes the frame buffer, intensity 3, scan limit 7
module led_matrix_frame_buffer_top import lmfb_pkg::*; #(
   parameter int BUFFER_ROWS  = BUFFER_ROWS_DEFAULT,
   parameter int VISIBLE_ROWS = VISIBLE_ROWS_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [2:0]           req_command,
   input  logic [COLUMN_W-1:0]  req_column,
   input  logic [LINE_W-1:0]    req_line,
   input  logic [ROW_W-1:0]     req_row_bits,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [ADDR_W-1:0]    rsp_reg_address,
   output logic [ROW_W-1:0]     rsp_reg_data,
   output logic                 rsp_last,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_write_data
);

   ctrl_type   ctrl;
   status_type status;

   lmfb_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_command (req_command),
      .status      (status),
      .ctrl        (ctrl)
   );

   lmfb_datapath #(
      .BUFFER_ROWS  (BUFFER_ROWS),
      .VISIBLE_ROWS (VISIBLE_ROWS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_column       (req_column),
      .req_line         (req_line),
      .req_row_bits     (req_row_bits),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .ctrl             (ctrl),
      .status           (status),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_reg_address  (rsp_reg_address),
      .rsp_reg_data     (rsp_reg_data),
      .rsp_last         (rsp_last)
   );

endmodule

// File: tb/led_matrix_frame_buffer_top_tb.sv
module led_matrix_frame_buffer_top_tb import lmfb_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int BUF_ROWS        = BUFFER_ROWS_DEFAULT;
   localparam int VIS_ROWS        = VISIBLE_ROWS_DEFAULT;
   localparam logic [2:0] CMD_UNUSED = 3'd7;
   localparam int SETTLE_CYCLES   = 16;
   localparam int QUIET_LIMIT     = 1000;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 75;
   localparam int DIRECTED_COUNT  = 24;

   typedef struct packed {
      logic [ADDR_W-1:0] addr;
      logic [ROW_W-1:0]  data;
      logic              last;
   } drv_word_type;

   typedef struct packed {
      logic [2:0]          cmd;
      logic [COLUMN_W-1:0] col;
      logic [LINE_W-1:0]   line;
      logic [ROW_W-1:0]    bits;
      logic                typed;
      logic [8*ROW_W-1:0]  view;
   } stim_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic [2:0]           req_command = '0;
   logic [COLUMN_W-1:0]  req_column = '0;
   logic [LINE_W-1:0]    req_line = '0;
   logic [ROW_W-1:0]     req_row_bits = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [ADDR_W-1:0]    rsp_reg_address;
   logic [ROW_W-1:0]     rsp_reg_data;
   logic                 rsp_last;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_write_data = '0;

   led_matrix_frame_buffer_top dut (.*);

   always #5 clock = ~clock;

   // shadow of the frame buffer and driver settings
   logic [ROW_W-1:0]    frame_model [BUF_ROWS];
   logic [INTENS_W-1:0] intensity_cfg = INTENSITY_RESET;
   logic [SCAN_W-1:0]   scan_cfg = SCAN_LIMIT_RESET;
   drv_word_type        pending_words [$];

   int failures = 0;
   int quiet_cycles = 0;
   int stall_left = 0;
   bit sender_idle_on = 1'b1;
   bit sink_idle_on = 1'b1;

   initial begin
      for (int r = 0; r < BUF_ROWS; r++) frame_model[r] = '0;
   end

   stim_row_type directed_rows [DIRECTED_COUNT] = '{
      '{CMD_REFRESH,   3'd0, 4'd0,  8'h00, 1'b1, 64'h0},
      '{CMD_INIT,      3'd0, 4'd0,  8'h00, 1'b1, 64'h0},
      '{CMD_SET_PIXEL, 3'd0, 4'd0,  8'h00, 1'b0, 64'h0},
      '{CMD_SET_PIXEL, 3'd7, 4'd7,  8'h00, 1'b0, 64'h0},
      '{CMD_SET_PIXEL, 3'd3, 4'd15, 8'hff, 1'b0, 64'h0},
      '{CMD_REFRESH,   3'd7, 4'd15, 8'hff, 1'b1, 64'h1100_0000_0000_0080},
      '{CMD_CLR_PIXEL, 3'd0, 4'd8,  8'h00, 1'b0, 64'h0},
      '{CMD_WRITE_ROW, 3'd0, 4'd15, 8'hff, 1'b0, 64'h0},
      '{CMD_WRITE_ROW, 3'd5, 4'd0,  8'ha5, 1'b0, 64'h0},
      '{CMD_WRITE_ROW, 3'd0, 4'd8,  8'h5a, 1'b0, 64'h0},
      '{CMD_REFRESH,   3'd0, 4'd0,  8'h00, 1'b1, 64'h1100_0000_0000_00a5},
      '{CMD_SHIFT,     3'd7, 4'd15, 8'hff, 1'b0, 64'h0},
      '{CMD_REFRESH,   3'd0, 4'd0,  8'h00, 1'b0, 64'h0},
      '{CMD_SHIFT,     3'd0, 4'd0,  8'h00, 1'b0, 64'h0},
      '{CMD_SHIFT,     3'd0, 4'd0,  8'h00, 1'b0, 64'h0},
      '{CMD_REFRESH,   3'd0, 4'd0,  8'h00, 1'b0, 64'h0},
      '{CMD_UNUSED,    3'd7, 4'd15, 8'hff, 1'b0, 64'h0},
      '{CMD_CLR_PIXEL, 3'd7, 4'd7,  8'h00, 1'b0, 64'h0},
      '{CMD_CLEAR_ALL, 3'd7, 4'd15, 8'hff, 1'b1, 64'h0},
      '{CMD_WRITE_ROW, 3'd0, 4'd3,  8'h81, 1'b0, 64'h0},
      '{CMD_SET_PIXEL, 3'd5, 4'd3,  8'h00, 1'b0, 64'h0},
      '{CMD_REFRESH,   3'd0, 4'd0,  8'h00, 1'b0, 64'h0},
      '{CMD_UNUSED,    3'd0, 4'd0,  8'h00, 1'b0, 64'h0},
      '{CMD_INIT,      3'd7, 4'd15, 8'hff, 1'b0, 64'h0}
   };

   // apply one command to the shadow buffer, queue the driver words it emits when keep is set
   function automatic void predict_driver_words(input logic [2:0] cmd,
                                                input logic [COLUMN_W-1:0] col,
                                                input logic [LINE_W-1:0] line,
                                                input logic [ROW_W-1:0] bits,
                                                input bit keep);
      case (cmd)
         CMD_INIT: begin
            if (keep) begin
               pending_words.push_back('{ADDR_DECODE, DATA_NO_DECODE, 1'b0});
               pending_words.push_back('{ADDR_INTENSITY, {4'd0, intensity_cfg}, 1'b0});
               pending_words.push_back('{ADDR_SCAN_LIMIT, {5'd0, scan_cfg}, 1'b0});
               pending_words.push_back('{ADDR_SHUTDOWN, DATA_RUN, 1'b0});
               pending_words.push_back('{ADDR_DISPLAY_TEST, DATA_TEST_OFF, 1'b1});
            end
         end
         CMD_SET_PIXEL: frame_model[line[2:0]] |= (8'h80 >> col);
         CMD_CLR_PIXEL: frame_model[line[2:0]] &= ~(8'h80 >> col);
         CMD_WRITE_ROW: begin
            if (line < BUF_ROWS) frame_model[line] = bits;
         end
         CMD_SHIFT: begin
            for (int r = 0; r < BUF_ROWS - 1; r++) frame_model[r] = frame_model[r + 1];
            frame_model[BUF_ROWS - 1] = '0;
         end
         CMD_REFRESH, CMD_CLEAR_ALL: begin
            if (cmd == CMD_CLEAR_ALL) begin
               for (int r = 0; r < BUF_ROWS; r++) frame_model[r] = '0;
            end
            if (keep) begin
               for (int r = 0; r < VIS_ROWS; r++)
                  pending_words.push_back('{ADDR_W'(r + 1), frame_model[r], r == VIS_ROWS - 1});
            end
         end
         default: ;
      endcase
   endfunction

   task automatic send_command(input logic [2:0] cmd, input logic [COLUMN_W-1:0] col,
                               input logic [LINE_W-1:0] line, input logic [ROW_W-1:0] bits);
      if (sender_idle_on && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_column   <= col;
      req_line     <= line;
      req_row_bits <= bits;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_words();
      req_valid <= 1'b0;
      while (pending_words.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DAT_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      if (idx == CSR_INTENSITY) intensity_cfg = data[INTENS_W-1:0];
      else scan_cfg = data[SCAN_W-1:0];
   endtask

   // result checker, sink stalls and watchdog
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready    <= 1'b0;
         stall_left   = 0;
         quiet_cycles = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_words.size() == 0) begin
               $error("beat with no expected word: reg_address %0h reg_data %0h last %0b",
                      rsp_reg_address, rsp_reg_data, rsp_last);
               failures++;
            end else begin
               drv_word_type want;
               want = pending_words.pop_front();
               if (rsp_reg_address !== want.addr) begin
                  $error("reg_address: expected %0h, actual %0h", want.addr, rsp_reg_address);
                  failures++;
               end
               if (rsp_reg_data !== want.data) begin
                  $error("reg_data: expected %0h, actual %0h", want.data, rsp_reg_data);
                  failures++;
               end
               if (rsp_last !== want.last) begin
                  $error("last: expected %0b, actual %0b", want.last, rsp_last);
                  failures++;
               end
            end
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else if (sink_idle_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 11);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      stim_row_type        row;
      logic [2:0]          cmd;
      logic [CSR_DAT_W-1:0] intens_val;
      logic [CSR_DAT_W-1:0] scan_val;
      int                  pick;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_COUNT; i++) begin
         row = directed_rows[i];
         send_command(row.cmd, row.col, row.line, row.bits);
         predict_driver_words(row.cmd, row.col, row.line, row.bits, !row.typed);
         if (row.typed) begin
            if (row.cmd == CMD_INIT) begin
               pending_words.push_back('{ADDR_DECODE, 8'h00, 1'b0});
               pending_words.push_back('{ADDR_INTENSITY, {4'd0, INTENSITY_RESET}, 1'b0});
               pending_words.push_back('{ADDR_SCAN_LIMIT, {5'd0, SCAN_LIMIT_RESET}, 1'b0});
               pending_words.push_back('{ADDR_SHUTDOWN, 8'h01, 1'b0});
               pending_words.push_back('{ADDR_DISPLAY_TEST, 8'h00, 1'b1});
            end else begin
               for (int r = 0; r < VIS_ROWS; r++)
                  pending_words.push_back('{ADDR_W'(r + 1), row.view[r*ROW_W +: ROW_W],
                                            r == VIS_ROWS - 1});
            end
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         drain_words();
         case (phase)
            0: begin
               intens_val = 4'd0;
               scan_val   = 4'd0;
            end
            1: begin
               intens_val = 4'hf;
               scan_val   = 4'hf;
            end
            default: begin
               intens_val = CSR_DAT_W'($urandom_range(0, 15));
               scan_val   = CSR_DAT_W'($urandom_range(0, 15));
            end
         endcase
         write_csr(CSR_INTENSITY, intens_val);
         write_csr(CSR_SCAN_LIMIT, scan_val);

         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n % 25 == 0) begin
               sender_idle_on = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
               sink_idle_on   = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
            end
            // sender holds off until the block has emptied its output
            if (phase == 1 && n == ITEMS_PER_PHASE / 2) drain_words();
            pick = $urandom_range(0, 99);
            if (pick < 22)      cmd = CMD_SET_PIXEL;
            else if (pick < 36) cmd = CMD_CLR_PIXEL;
            else if (pick < 56) cmd = CMD_WRITE_ROW;
            else if (pick < 66) cmd = CMD_SHIFT;
            else if (pick < 86) cmd = CMD_REFRESH;
            else if (pick < 91) cmd = CMD_INIT;
            else if (pick < 95) cmd = CMD_CLEAR_ALL;
            else                cmd = CMD_UNUSED;
            row.col  = COLUMN_W'($urandom_range(0, 7));
            row.line = LINE_W'($urandom_range(0, 15));
            row.bits = ROW_W'($urandom_range(0, 255));
            send_command(cmd, row.col, row.line, row.bits);
            predict_driver_words(cmd, row.col, row.line, row.bits, 1'b1);
         end
      end

      drain_words();
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
